// ----- src/fdtt_pkg.sv -----
// Package for the first-demand tracking table: sizes, action and state codes, command and status structs.
// Used by every module of the block; depends on nothing.
package fdtt_pkg;
	localparam int unsigned TableEntries = 16;
	localparam int unsigned ClassCount = 4;
	localparam int unsigned KeyBits = 64;
	localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

	localparam logic ActNote = 1'b0;
	localparam logic ActFind = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_note;
	} sts_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == Sat32) ? v : v + 32'd1;
	endfunction
endpackage

// ----- src/fdtt_ctrl.sv -----
// Controller of the first-demand tracking table: sequences capture, lookup, commit, output.
// Depends on fdtt_pkg.
module fdtt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  fdtt_pkg::sts_t   sts,
	output fdtt_pkg::cmd_t   cmd
);
	fdtt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdtt_pkg::ST_IDLE: begin
				if (in_valid) state_d = fdtt_pkg::ST_LOOKUP;
			end
			fdtt_pkg::ST_LOOKUP: begin
				state_d = fdtt_pkg::ST_WRITE;
			end
			fdtt_pkg::ST_WRITE: begin
				state_d = fdtt_pkg::ST_OUT;
			end
			fdtt_pkg::ST_OUT: begin
				if (out_ready) state_d = in_valid ? fdtt_pkg::ST_LOOKUP : fdtt_pkg::ST_IDLE;
			end
			default: state_d = fdtt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			fdtt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			fdtt_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			fdtt_pkg::ST_WRITE: begin
				cmd.commit = sts.is_note;
				cmd.load_out = 1'b1;
			end
			fdtt_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				cmd.capture = out_ready & in_valid;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == fdtt_pkg::ST_OUT))
		else $error("commit not followed by output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdtt_pkg::ST_LOOKUP) |=> (state_q == fdtt_pkg::ST_WRITE))
		else $error("lookup did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == fdtt_pkg::ST_LOOKUP))
		else $error("accepted beat not looked up");
endmodule

// ----- src/fdtt_dp.sv -----
// Datapath of the first-demand tracking table: entry registers, parallel match,
// victim search, counters and output register. Depends on fdtt_pkg.
module fdtt_dp #(
	parameter int unsigned TABLE_ENTRIES = fdtt_pkg::TableEntries,
	parameter int unsigned CLASS_COUNT = fdtt_pkg::ClassCount,
	parameter int unsigned KEY_BITS = fdtt_pkg::KeyBits
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fdtt_pkg::cmd_t cmd,
	output fdtt_pkg::sts_t sts,
	input  logic           action,
	input  logic [63:0]    key_value,
	input  logic           key_clear,
	input  logic [63:0]    generation,
	input  logic [63:0]    demand_time,
	input  logic [2:0]     demand_class,
	output logic           accepted,
	output logic           found,
	output logic [63:0]    first_time,
	output logic [63:0]    last_time,
	output logic [31:0]    hit_count,
	output logic [1:0]     entry_class,
	output logic [31:0]    duplicate_total,
	output logic [31:0]    reclass_total,
	output logic [31:0]    eviction_total,
	output logic [31:0]    class_total
);
	localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned ClsW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

	// captured item
	logic                action_q, clear_q;
	logic [KEY_BITS-1:0] key_q;
	logic [63:0]         gen_q, time_q;
	logic [2:0]          cls_q;

	// entry storage
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [KEY_BITS-1:0]      key_tab_q [TABLE_ENTRIES];
	logic [63:0]              gen_tab_q [TABLE_ENTRIES];
	logic [63:0]              ft_tab_q [TABLE_ENTRIES];
	logic [63:0]              lt_tab_q [TABLE_ENTRIES];
	logic [31:0]              cnt_tab_q [TABLE_ENTRIES];
	logic [1:0]               kind_tab_q [TABLE_ENTRIES];

	logic [31:0] dup_q, recl_q, evict_q;
	logic [31:0] cls_cnt_q [CLASS_COUNT];

	// lookup results, registered in the lookup cycle
	logic [TABLE_ENTRIES-1:0] keyhit_s1, fullhit_s1;
	logic [TABLE_ENTRIES-1:0] keyhit, fullhit;
	logic [IdxW-1:0]          kslot_s1, fslot_s1, vslot_s1;
	logic                     khit_s1, fhit_s1, evict_s1;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			keyhit[i] = vld_q[i] && (key_tab_q[i] == key_q);
			fullhit[i] = keyhit[i] && (gen_tab_q[i] == gen_q);
		end
	end

	// priority encoders; victim found by a compare tree over the last times,
	// where the left (lower index) side wins a tie
	logic [IdxW-1:0] kslot, fslot, fslot_d, vslot, oldest;
	logic            khit, fhit, have_free;
	logic [63:0]     lt_red [TABLE_ENTRIES];
	logic [IdxW-1:0] ix_red [TABLE_ENTRIES];
	always_comb begin
		kslot = '0; khit = 1'b0;
		fslot = '0; fhit = 1'b0;
		vslot = '0; have_free = 1'b0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (keyhit[i]) begin kslot = IdxW'(i); khit = 1'b1; end
			if (fullhit[i]) begin fslot = IdxW'(i); fhit = 1'b1; end
			if (!vld_q[i]) begin vslot = IdxW'(i); have_free = 1'b1; end
		end
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			lt_red[i] = lt_tab_q[i];
			ix_red[i] = IdxW'(i);
		end
		for (int s = 1; s < TABLE_ENTRIES; s = s * 2) begin
			for (int i = 0; i + s < TABLE_ENTRIES; i = i + 2 * s) begin
				if (lt_red[i + s] < lt_red[i]) begin
					lt_red[i] = lt_red[i + s];
					ix_red[i] = ix_red[i + s];
				end
			end
		end
		oldest = ix_red[0];
		if (!have_free) vslot = oldest;
		fslot_d = fslot;
	end

	logic cls_ok;
	assign cls_ok = ({29'd0, cls_q} < 32'(CLASS_COUNT));
	logic note_ok;
	assign note_ok = (action_q == fdtt_pkg::ActNote) && !clear_q && cls_ok;
	assign sts.is_note = note_ok;

	logic [ClsW-1:0] cls_idx;
	assign cls_idx = cls_q[ClsW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			clear_q <= key_clear;
			key_q <= key_value[KEY_BITS-1:0];
			gen_q <= generation;
			time_q <= demand_time;
			cls_q <= demand_class;
		end
		if (cmd.lookup) begin
			keyhit_s1 <= keyhit;
			fullhit_s1 <= fullhit;
			kslot_s1 <= kslot;
			khit_s1 <= khit;
			fslot_s1 <= fslot_d;
			fhit_s1 <= fhit;
			vslot_s1 <= vslot;
			evict_s1 <= !have_free;
		end
	end

	// entry write-back
	logic dup_case;
	logic [IdxW-1:0] wslot;
	assign dup_case = khit_s1 && fullhit_s1[kslot_s1];
	assign wslot = khit_s1 ? kslot_s1 : vslot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			dup_q <= '0;
			recl_q <= '0;
			evict_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				key_tab_q[i] <= '0; gen_tab_q[i] <= '0; ft_tab_q[i] <= '0;
				lt_tab_q[i] <= '0; cnt_tab_q[i] <= '0; kind_tab_q[i] <= '0;
			end
			for (int c = 0; c < CLASS_COUNT; c++) cls_cnt_q[c] <= '0;
		end else if (cmd.commit) begin
			if (dup_case) begin
				lt_tab_q[kslot_s1] <= time_q;
				cnt_tab_q[kslot_s1] <= fdtt_pkg::sat_inc(cnt_tab_q[kslot_s1]);
				dup_q <= fdtt_pkg::sat_inc(dup_q);
			end else begin
				if (khit_s1) recl_q <= fdtt_pkg::sat_inc(recl_q);
				else if (evict_s1) evict_q <= fdtt_pkg::sat_inc(evict_q);
				vld_q[wslot] <= 1'b1;
				key_tab_q[wslot] <= key_q;
				gen_tab_q[wslot] <= gen_q;
				ft_tab_q[wslot] <= time_q;
				lt_tab_q[wslot] <= time_q;
				cnt_tab_q[wslot] <= 32'd1;
				kind_tab_q[wslot] <= cls_q[1:0];
				cls_cnt_q[cls_idx] <= fdtt_pkg::sat_inc(cls_cnt_q[cls_idx]);
			end
		end
	end

	// result: counters after the commit, so mirror its effect here
	logic [31:0] dup_n, recl_n, evict_n, clsc_n;
	logic        acc_n, fnd_n;
	always_comb begin
		dup_n = dup_q; recl_n = recl_q; evict_n = evict_q;
		clsc_n = cls_ok ? cls_cnt_q[cls_idx] : 32'd0;
		acc_n = 1'b0;
		if (note_ok) begin
			if (dup_case) dup_n = fdtt_pkg::sat_inc(dup_q);
			else begin
				acc_n = 1'b1;
				clsc_n = fdtt_pkg::sat_inc(cls_cnt_q[cls_idx]);
				if (khit_s1) recl_n = fdtt_pkg::sat_inc(recl_q);
				else if (evict_s1) evict_n = fdtt_pkg::sat_inc(evict_q);
			end
		end
		fnd_n = (action_q == fdtt_pkg::ActFind) && !clear_q && fhit_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			accepted <= acc_n;
			found <= fnd_n;
			first_time <= fnd_n ? ft_tab_q[fslot_s1] : 64'd0;
			last_time <= fnd_n ? lt_tab_q[fslot_s1] : 64'd0;
			hit_count <= fnd_n ? cnt_tab_q[fslot_s1] : 32'd0;
			entry_class <= fnd_n ? kind_tab_q[fslot_s1] : 2'd0;
			duplicate_total <= dup_n;
			reclass_total <= recl_n;
			eviction_total <= evict_n;
			class_total <= clsc_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> $onehot0(fullhit_s1 & ~keyhit_s1) == 1'b1 && (fullhit_s1 & ~keyhit_s1) == '0)
		else $error("full hit without key hit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !dup_case) |=> vld_q[$past(wslot)])
		else $error("written entry not valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (!accepted || !found))
		else $error("accepted and found together");
endmodule

// ----- src/first_demand_tracking_table_top.sv -----
// Top level of the first-demand tracking table: controller plus datapath.
// Depends on fdtt_pkg, fdtt_ctrl and fdtt_dp.
//
// Tracks up to TABLE_ENTRIES keys with generation, first/last demand time, a
// demand count and a class. After a beat is accepted, a lookup state compares
// all entries in parallel and chooses the free slot or oldest victim, and a
// write-back state commits a note and also loads the output register. The
// result is then offered until it is taken. The next beat is accepted on the
// edge that hands the result away, so a new beat is not taken while the last
// one is still in the compare, the write-back or the offered result. The
// table clears at reset.
module first_demand_tracking_table_top #(
	parameter int unsigned TABLE_ENTRIES = fdtt_pkg::TableEntries,
	parameter int unsigned CLASS_COUNT = fdtt_pkg::ClassCount,
	parameter int unsigned KEY_BITS = fdtt_pkg::KeyBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [63:0] key_value,
	input  logic        key_clear,
	input  logic [63:0] generation,
	input  logic [63:0] demand_time,
	input  logic [2:0]  demand_class,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        found,
	output logic [63:0] first_time,
	output logic [63:0] last_time,
	output logic [31:0] hit_count,
	output logic [1:0]  entry_class,
	output logic [31:0] duplicate_total,
	output logic [31:0] reclass_total,
	output logic [31:0] eviction_total,
	output logic [31:0] class_total
);
	fdtt_pkg::cmd_t cmd;
	fdtt_pkg::sts_t sts;

	// sequence each beat: capture, lookup, commit, hold the result
	fdtt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	fdtt_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES), .CLASS_COUNT(CLASS_COUNT), .KEY_BITS(KEY_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.action(action), .key_value(key_value), .key_clear(key_clear),
		.generation(generation), .demand_time(demand_time),
		.demand_class(demand_class),
		.accepted(accepted), .found(found), .first_time(first_time),
		.last_time(last_time), .hit_count(hit_count), .entry_class(entry_class),
		.duplicate_total(duplicate_total), .reclass_total(reclass_total),
		.eviction_total(eviction_total), .class_total(class_total)
	);
endmodule

// ----- verif/fdtt_checker.sv -----
// Scoreboard for the first-demand tracking table: watches both channels, keeps its
// own copy of the table and counters, and compares each result beat field by field.
// Depends on fdtt_pkg for sizes and action codes.
module fdtt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic [63:0] key_value,
	input  logic        key_clear,
	input  logic [63:0] generation,
	input  logic [63:0] demand_time,
	input  logic [2:0]  demand_class,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        accepted,
	input  logic        found,
	input  logic [63:0] first_time,
	input  logic [63:0] last_time,
	input  logic [31:0] hit_count,
	input  logic [1:0]  entry_class,
	input  logic [31:0] duplicate_total,
	input  logic [31:0] reclass_total,
	input  logic [31:0] eviction_total,
	input  logic [31:0] class_total,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        accepted;
		logic        found;
		logic [63:0] first_time;
		logic [63:0] last_time;
		logic [31:0] hit_count;
		logic [1:0]  entry_class;
		logic [31:0] duplicate_total;
		logic [31:0] reclass_total;
		logic [31:0] eviction_total;
		logic [31:0] class_total;
	} demand_reply_t;

	logic        tbl_valid [fdtt_pkg::TableEntries];
	logic [63:0] tbl_key   [fdtt_pkg::TableEntries];
	logic [63:0] tbl_gen   [fdtt_pkg::TableEntries];
	logic [63:0] tbl_first [fdtt_pkg::TableEntries];
	logic [63:0] tbl_last  [fdtt_pkg::TableEntries];
	logic [31:0] tbl_count [fdtt_pkg::TableEntries];
	logic [1:0]  tbl_kind  [fdtt_pkg::TableEntries];
	logic [31:0] dup_cnt, reclass_cnt, evict_cnt;
	logic [31:0] per_class [fdtt_pkg::ClassCount];
	demand_reply_t reply_queue[$];

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic demand_reply_t track_demand(input logic act, input logic [63:0] key,
			input logic clr, input logic [63:0] gen, input logic [63:0] t,
			input logic [2:0] cls);
		demand_reply_t r;
		int slot;
		int oldest;
		r = '{default: '0};
		if (act == fdtt_pkg::ActNote) begin
			if (!clr && cls < fdtt_pkg::ClassCount) begin
				slot = -1;
				for (int i = 0; i < fdtt_pkg::TableEntries; i++)
					if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
				if (slot >= 0 && tbl_gen[slot] == gen) begin
					tbl_last[slot] = t;
					tbl_count[slot] = bump(tbl_count[slot]);
					dup_cnt = bump(dup_cnt);
				end else begin
					if (slot >= 0) begin
						reclass_cnt = bump(reclass_cnt);
					end else begin
						oldest = 0;
						for (int i = 0; i < fdtt_pkg::TableEntries; i++) begin
							if (slot < 0 && !tbl_valid[i]) slot = i;
							if (tbl_last[i] < tbl_last[oldest]) oldest = i;
						end
						if (slot < 0) begin
							slot = oldest;
							evict_cnt = bump(evict_cnt);
						end
					end
					tbl_valid[slot] = 1'b1;
					tbl_key[slot] = key;
					tbl_gen[slot] = gen;
					tbl_first[slot] = t;
					tbl_last[slot] = t;
					tbl_count[slot] = 32'd1;
					tbl_kind[slot] = cls[1:0];
					per_class[cls] = bump(per_class[cls]);
					r.accepted = 1'b1;
				end
			end
		end else if (!clr) begin
			for (int i = 0; i < fdtt_pkg::TableEntries; i++) begin
				if (!r.found && tbl_valid[i] && tbl_gen[i] == gen && tbl_key[i] == key) begin
					r.found = 1'b1;
					r.first_time = tbl_first[i];
					r.last_time = tbl_last[i];
					r.hit_count = tbl_count[i];
					r.entry_class = tbl_kind[i];
				end
			end
		end
		r.duplicate_total = dup_cnt;
		r.reclass_total = reclass_cnt;
		r.eviction_total = evict_cnt;
		r.class_total = (cls < fdtt_pkg::ClassCount) ? per_class[cls] : 32'd0;
		return r;
	endfunction

	// report one field; returns 0 on a mismatch
	function automatic bit field_ok(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		demand_reply_t exp_r;
		bit bad;
		if (!arst_n) begin
			for (int i = 0; i < fdtt_pkg::TableEntries; i++) begin
				tbl_valid[i] = 0; tbl_key[i] = 0; tbl_gen[i] = 0; tbl_first[i] = 0;
				tbl_last[i] = 0; tbl_count[i] = 0; tbl_kind[i] = 0;
			end
			for (int c = 0; c < fdtt_pkg::ClassCount; c++) per_class[c] = 0;
			dup_cnt = 0; reclass_cnt = 0; evict_cnt = 0;
			fail_count = 0;
			reply_queue.delete();
			pending_count = 0;
		end else begin
			// check the result beat first, then model the new input beat
			if (out_valid && out_ready) begin
				if (reply_queue.size() == 0) begin
					$error("result beat with no expectation pending");
					fail_count++;
				end else begin
					exp_r = reply_queue.pop_front();
					bad = 0;
					if (!field_ok("accepted", 64'(exp_r.accepted), 64'(accepted))) bad = 1;
					if (!field_ok("found", 64'(exp_r.found), 64'(found))) bad = 1;
					if (!field_ok("first_time", exp_r.first_time, first_time)) bad = 1;
					if (!field_ok("last_time", exp_r.last_time, last_time)) bad = 1;
					if (!field_ok("hit_count", 64'(exp_r.hit_count), 64'(hit_count)))
						bad = 1;
					if (!field_ok("entry_class", 64'(exp_r.entry_class), 64'(entry_class)))
						bad = 1;
					if (!field_ok("duplicate_total", 64'(exp_r.duplicate_total),
							64'(duplicate_total))) bad = 1;
					if (!field_ok("reclass_total", 64'(exp_r.reclass_total),
							64'(reclass_total))) bad = 1;
					if (!field_ok("eviction_total", 64'(exp_r.eviction_total),
							64'(eviction_total))) bad = 1;
					if (!field_ok("class_total", 64'(exp_r.class_total), 64'(class_total)))
						bad = 1;
					if (bad) fail_count++;
				end
			end
			if (in_valid && in_ready)
				reply_queue.push_back(track_demand(action, key_value, key_clear, generation,
					demand_time, demand_class));
			pending_count = reply_queue.size();
		end
	end
endmodule

// ----- verif/testbench.sv -----
// Top of the first-demand tracking table testbench: clock, reset, stimulus and verdict.
// Depends on fdtt_pkg, first_demand_tracking_table_top and fdtt_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        action = fdtt_pkg::ActNote;
	logic [63:0] key_value = 0;
	logic        key_clear = 0;
	logic [63:0] generation = 0;
	logic [63:0] demand_time = 0;
	logic [2:0]  demand_class = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        accepted, found;
	logic [63:0] first_time, last_time;
	logic [31:0] hit_count;
	logic [1:0]  entry_class;
	logic [31:0] duplicate_total, reclass_total, eviction_total, class_total;
	int          fail_count, pending_count;

	localparam int WatchdogLimit = 2000;
	localparam int LongStall = 60;
	int  idle_cycles = 0;
	bit  sink_hold = 0;   // set by stimulus to ask for one long receiver stall
	bit  hold_done = 0;   // set by the receiver once that stall has run
	int  n_notes = 0, n_finds = 0;

	// small pools of keys and generations so that duplicates, reclassifications
	// and finds that hit are common
	logic [63:0] key_pool [8];
	logic [63:0] gen_pool [4];
	logic [63:0] clock_now = 64'd1000;

	first_demand_tracking_table_top DUT (.*);
	fdtt_checker u_checker (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Count cycles with no beat on either channel; give up when stuck.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no beat for %0d cycles", WatchdogLimit);
			$display("[first_demand_tracking_table_top] ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: random stalls, plus one long hold-off set by LongStall when asked.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold && !hold_done) begin
				out_ready <= 0;
				repeat (LongStall) @(posedge clk);
				hold_done = 1;
			end else begin
				g = gap_len();
				if (g > 0 && $urandom_range(0, 2) == 0) begin
					out_ready <= 0;
					repeat (g) @(posedge clk);
				end
				out_ready <= 1;
			end
		end
	end

	// Drive one beat and hold it until it is accepted.
	task automatic send_beat(input logic act, input logic [63:0] key, input logic clr,
			input logic [63:0] gen, input logic [63:0] t, input logic [2:0] cls);
		action <= act;
		key_value <= key;
		key_clear <= clr;
		generation <= gen;
		demand_time <= t;
		demand_class <= cls;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (act == fdtt_pkg::ActNote) n_notes++;
		else n_finds++;
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [63:0] k, g, t;
		logic        act, clr;
		logic [2:0]  cls;
		int          r, gap;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 8; i++) key_pool[i] = rand64();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 0; i < 4; i++) gen_pool[i] = rand64();
		gen_pool[0] = '0;
		gen_pool[1] = '1;

		// Directed: fresh note, duplicate, find, reclassification, rejects,
		// wide class, find with clear key, find miss, extreme times.
		send_beat(fdtt_pkg::ActNote, '0, 0, '0, '0, 3'd0);
		send_beat(fdtt_pkg::ActNote, '0, 0, '0, '1, 3'd1);
		send_beat(fdtt_pkg::ActFind, '0, 0, '0, '0, 3'd0);
		send_beat(fdtt_pkg::ActNote, '0, 0, '1, 64'd5, 3'd2);
		send_beat(fdtt_pkg::ActFind, '0, 0, '1, '0, 3'd2);
		send_beat(fdtt_pkg::ActNote, '1, 1, '1, '1, 3'd3);
		send_beat(fdtt_pkg::ActNote, '1, 0, '1, '1, 3'd4);
		send_beat(fdtt_pkg::ActNote, '1, 0, '1, '1, 3'd7);
		send_beat(fdtt_pkg::ActFind, '1, 0, '1, '0, 3'd7);
		send_beat(fdtt_pkg::ActNote, '1, 0, '1, '1, 3'd3);
		send_beat(fdtt_pkg::ActFind, '1, 0, '1, '0, 3'd3);
		send_beat(fdtt_pkg::ActFind, '1, 1, '1, '0, 3'd3);
		send_beat(fdtt_pkg::ActFind, 64'h1234, 0, '0, '0, 3'd5);
		// fill every slot, then force evictions (equal last times tie to lowest index)
		for (int i = 0; i < fdtt_pkg::TableEntries + 3; i++)
			send_beat(fdtt_pkg::ActNote, 64'hA000 + i, 0, 64'd7, 64'd100, i[2:0] & 3'd3);
		send_beat(fdtt_pkg::ActFind, 64'hA000 + fdtt_pkg::TableEntries, 0, 64'd7, '0, 3'd0);

		// Pressure: the receiver holds off for a long stretch while the sender keeps offering beats.
		sink_hold = 1;
		for (int i = 0; i < 6; i++)
			send_beat(fdtt_pkg::ActFind, 64'hA000 + i, 0, 64'd7, '0, 3'd1);
		sink_hold = 0;

		// Pressure: pause the sender until every expected result has come.
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);

		// Random: notes and finds, mostly over a small key/generation space.
		for (int n = 0; n < 850; n++) begin
			r = $urandom_range(0, 99);
			k = (r < 85) ? key_pool[$urandom_range(0, 7)] : rand64();
			g = ($urandom_range(0, 9) < 8) ? gen_pool[$urandom_range(0, 3)] : rand64();
			act = ($urandom_range(0, 99) < 55) ? fdtt_pkg::ActNote : fdtt_pkg::ActFind;
			clr = ($urandom_range(0, 19) == 0);
			cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
			                                  : 3'($urandom_range(0, 3));
			r = $urandom_range(0, 19);
			if (r == 0) t = rand64();
			else if (r == 1) t = '0;
			else if (r == 2) t = '1;
			else begin
				clock_now = clock_now + $urandom_range(0, 50);
				t = clock_now;
			end
			send_beat(act, k, clr, g, t, cls);
			gap = gap_len();
			if (gap > 0) pause_sender(gap);
		end
		in_valid <= 0;

		// Drain, then let the pipeline settle.
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d notes and %0d finds incl. rejects, reclassification, evictions",
			n_notes, n_finds);
		if (fail_count == 0)
			$display("[first_demand_tracking_table_top] OK");
		else
			$display("[first_demand_tracking_table_top] ERROR");
		$finish;
	end
endmodule
